/* sv/hfb_pkg.sv */
// Shared types, constants and the CRC step for the heartbeat frame builder.
// Used by the core and by its port checker; depends on nothing else.
package hfb_pkg;

  typedef logic [7:0]  byte_t;
  typedef logic [15:0] crc_t;
  typedef logic [4:0]  pos_t;
  typedef logic [2:0]  cfg_idx_t;
  typedef logic [31:0] cfg_data_t;

  // Frame geometry.
  localparam int unsigned FRAME_BYTES = 21;
  localparam byte_t       PAYLOAD_LEN = 8'd9;
  localparam crc_t        CRC_INIT    = 16'hFFFF;

  // Byte positions within a frame.
  localparam pos_t POS_START   = 5'd0;
  localparam pos_t POS_LEN     = 5'd1;
  localparam pos_t POS_SEQ     = 5'd4;
  localparam pos_t POS_SYS     = 5'd5;
  localparam pos_t POS_COMP    = 5'd6;
  localparam pos_t POS_MODE0   = 5'd10;
  localparam pos_t POS_MODE1   = 5'd11;
  localparam pos_t POS_MODE2   = 5'd12;
  localparam pos_t POS_MODE3   = 5'd13;
  localparam pos_t POS_VEHICLE = 5'd14;
  localparam pos_t POS_AUTOPIL = 5'd15;
  localparam pos_t POS_STATE   = 5'd18;
  localparam pos_t POS_CRC_LO  = 5'd19;
  localparam pos_t POS_CRC_HI  = pos_t'(FRAME_BYTES - 1);

  // Configuration register indexes.
  localparam cfg_idx_t REG_START_MARKER   = 3'd0;
  localparam cfg_idx_t REG_CUSTOM_MODE    = 3'd1;
  localparam cfg_idx_t REG_VEHICLE_TYPE   = 3'd2;
  localparam cfg_idx_t REG_AUTOPILOT_TYPE = 3'd3;
  localparam cfg_idx_t REG_STATE_BYTE     = 3'd4;
  localparam cfg_idx_t REG_CRC_EXTRA      = 3'd5;

  // Register values after reset.
  localparam byte_t       RST_START_MARKER   = 8'd253;
  localparam logic [31:0] RST_CUSTOM_MODE    = 32'd0;
  localparam byte_t       RST_VEHICLE_TYPE   = 8'd18;
  localparam byte_t       RST_AUTOPILOT_TYPE = 8'd8;
  localparam byte_t       RST_STATE_BYTE     = 8'd3;
  localparam byte_t       RST_CRC_EXTRA      = 8'd50;

  // One byte of the X.25 CRC-16, least significant bit first.
  function automatic crc_t crc_fold(input crc_t crc, input byte_t b);
    byte_t t;
    t = b ^ crc[7:0];
    t = t ^ byte_t'(t << 4);
    return {8'h00, crc[15:8]} ^ {t, 8'h00} ^ {5'b00000, t, 3'b000} ^ {12'h000, t[7:4]};
  endfunction

endpackage

/* sv/heartbeat_frame_builder_core.sv */
// Heartbeat frame builder: turns each request into a 21-byte framed message.
// Depends on hfb_pkg for types, byte positions, register codes and the CRC step.
//
// Usage
//   Input channel (in_valid / in_stall) carries one request per transfer:
//   sequence number, system id and component id. Each request yields a
//   21-byte frame on the output channel (out_valid / out_stall), one byte per
//   transfer, with out_frame_end set on the final CRC high byte.
//   A request sits in a one-entry holding register until the serialiser is
//   free, so the next request can be taken while the current frame is sent.
//   A request passes through the holding register and the serialiser state
//   before its first byte is loaded into the output register.
//   The output register takes one byte per cycle while it is not stalled,
//   and the CRC register folds the length to state bytes in turn (the extra
//   byte with the state byte); frames follow each other with no gap.
//   Configuration writes (cfg_write, cfg_index, cfg_data) are registered
//   and should only be made while no frame is pending or in flight.
//   Reset (rst_n low, synchronous) restores the register defaults, empties the
//   holding register and drops out_valid.
//   While a presented byte is stalled it holds and the serialiser waits.
module heartbeat_frame_builder_core (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  hfb_pkg::byte_t     in_sequence_number,
  input  hfb_pkg::byte_t     in_system_ident,
  input  hfb_pkg::byte_t     in_component_ident,
  output logic               out_valid,
  input  logic               out_stall,
  output hfb_pkg::byte_t     out_frame_byte,
  output logic               out_frame_end,
  input  logic               cfg_write,
  input  hfb_pkg::cfg_idx_t  cfg_index,
  input  hfb_pkg::cfg_data_t cfg_data
);
  import hfb_pkg::*;

  // Configuration registers.
  byte_t       start_marker_r;
  logic [31:0] custom_mode_r;
  byte_t       vehicle_type_r;
  byte_t       autopilot_type_r;
  byte_t       state_byte_r;
  byte_t       crc_extra_r;

  // Holding register for one request.
  logic        pend_valid_r;
  byte_t       pend_seq_r;
  byte_t       pend_sys_r;
  byte_t       pend_comp_r;

  // Serialiser state.
  logic        busy_r;
  pos_t        pos_r;
  crc_t        crc_r;
  byte_t       lat_seq_r;
  byte_t       lat_sys_r;
  byte_t       lat_comp_r;

  // Output register.
  logic        out_valid_r;
  byte_t       out_byte_r;
  logic        out_end_r;

  logic        in_xfer;
  logic        advance;
  logic        last_byte;
  logic        load;
  byte_t       byte_nxt;
  crc_t        crc_nxt;
  crc_t        crc_fold1;

  assign in_stall       = pend_valid_r;
  assign in_xfer        = in_valid && !pend_valid_r;
  assign out_valid      = out_valid_r;
  assign out_frame_byte = out_byte_r;
  assign out_frame_end  = out_end_r;

  // The serialiser moves on whenever the output register is free or drained.
  assign advance   = busy_r && (!out_valid_r || !out_stall);
  assign last_byte = (pos_r == POS_CRC_HI);
  assign load      = pend_valid_r && (!busy_r || (advance && last_byte));

  // Frame byte at the current position.
  always_comb begin
    unique case (pos_r)
      POS_START:   byte_nxt = start_marker_r;
      POS_LEN:     byte_nxt = PAYLOAD_LEN;
      POS_SEQ:     byte_nxt = lat_seq_r;
      POS_SYS:     byte_nxt = lat_sys_r;
      POS_COMP:    byte_nxt = lat_comp_r;
      POS_MODE0:   byte_nxt = custom_mode_r[7:0];
      POS_MODE1:   byte_nxt = custom_mode_r[15:8];
      POS_MODE2:   byte_nxt = custom_mode_r[23:16];
      POS_MODE3:   byte_nxt = custom_mode_r[31:24];
      POS_VEHICLE: byte_nxt = vehicle_type_r;
      POS_AUTOPIL: byte_nxt = autopilot_type_r;
      POS_STATE:   byte_nxt = state_byte_r;
      POS_CRC_LO:  byte_nxt = crc_r[7:0];
      POS_CRC_HI:  byte_nxt = crc_r[15:8];
      default:     byte_nxt = 8'h00;
    endcase
  end

  // CRC covers everything after the start byte up to the state byte, and the
  // extra byte is folded in straight after the state byte.
  always_comb begin
    crc_fold1 = crc_fold(crc_r, byte_nxt);
    if (pos_r == POS_START || pos_r == POS_CRC_LO || pos_r == POS_CRC_HI) begin
      crc_nxt = crc_r;
    end else if (pos_r == POS_STATE) begin
      crc_nxt = crc_fold(crc_fold1, crc_extra_r);
    end else begin
      crc_nxt = crc_fold1;
    end
  end

  // Configuration writes; indexes beyond the register list are ignored.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_marker_r   <= RST_START_MARKER;
      custom_mode_r    <= RST_CUSTOM_MODE;
      vehicle_type_r   <= RST_VEHICLE_TYPE;
      autopilot_type_r <= RST_AUTOPILOT_TYPE;
      state_byte_r     <= RST_STATE_BYTE;
      crc_extra_r      <= RST_CRC_EXTRA;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_START_MARKER:   start_marker_r   <= cfg_data[7:0];
        REG_CUSTOM_MODE:    custom_mode_r    <= cfg_data;
        REG_VEHICLE_TYPE:   vehicle_type_r   <= cfg_data[7:0];
        REG_AUTOPILOT_TYPE: autopilot_type_r <= cfg_data[7:0];
        REG_STATE_BYTE:     state_byte_r     <= cfg_data[7:0];
        REG_CRC_EXTRA:      crc_extra_r      <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // Holding register: filled by an input transfer, emptied by a frame load.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_valid_r <= 1'b0;
    end else if (in_xfer) begin
      pend_valid_r <= 1'b1;
    end else if (load) begin
      pend_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      pend_seq_r  <= in_sequence_number;
      pend_sys_r  <= in_system_ident;
      pend_comp_r <= in_component_ident;
    end
  end

  // Serialiser control: position counter, CRC register and busy flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      pos_r  <= POS_START;
      crc_r  <= CRC_INIT;
    end else if (load) begin
      busy_r <= 1'b1;
      pos_r  <= POS_START;
      crc_r  <= CRC_INIT;
    end else if (advance) begin
      if (last_byte) begin
        busy_r <= 1'b0;
        pos_r  <= POS_START;
        crc_r  <= CRC_INIT;
      end else begin
        pos_r  <= pos_r + 5'd1;
        crc_r  <= crc_nxt;
      end
    end
  end

  // Request fields held for the whole frame.
  always_ff @(posedge clk) begin
    if (load) begin
      lat_seq_r  <= pend_seq_r;
      lat_sys_r  <= pend_sys_r;
      lat_comp_r <= pend_comp_r;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_byte_r <= byte_nxt;
      out_end_r  <= last_byte;
    end
  end

endmodule

/* sv/hfb_checker.sv */
// Port-level checker for the heartbeat frame builder, bound to the core.
// Depends on hfb_pkg for the frame length and on the core's port names.
module hfb_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input hfb_pkg::byte_t     out_frame_byte,
  input logic               out_frame_end
);
  import hfb_pkg::*;

  logic out_xfer;
  pos_t out_cnt_r;

  assign out_xfer = out_valid && !out_stall;

  // Count output transfers within the current frame.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_cnt_r <= POS_START;
    end else if (out_xfer) begin
      out_cnt_r <= out_frame_end ? POS_START : out_cnt_r + 5'd1;
    end
  end

  // Nothing is presented in the cycle after reset.
  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("output valid straight after reset");

  // A stalled byte holds its value.
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_frame_byte) && $stable(out_frame_end))
    else $error("stalled output changed");

  // The end mark falls on the last byte of every frame and nowhere else.
  a_end_pos: assert property (@(posedge clk) disable iff (!rst_n)
    out_xfer |-> (out_frame_end == (out_cnt_r == POS_CRC_HI)))
    else $error("frame end mark out of place");

  // An accepted request occupies the holding slot in the next cycle.
  a_hold_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("request accepted without filling the holding slot");

endmodule

bind heartbeat_frame_builder_core hfb_checker u_hfb_checker (.*);

/* verif/tb_top.sv */
`timescale 1ns / 100ps
// Self-checking testbench for heartbeat_frame_builder_core: directed table, then random phases.
// Depends on hfb_pkg and the core; frames are predicted here and checked byte by byte.
module tb_top;
  import hfb_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 200000;
  localparam int unsigned DRAIN_CYCLES = 8;
  localparam int unsigned HOLD_CYCLES  = 250;
  localparam int unsigned PHASES       = 8;
  localparam int unsigned PHASE_ITEMS  = 50;
  localparam int unsigned IDLE_PCT     = 29;
  localparam crc_t        X25_POLY_REV = 16'h8408;

  // Register indexes that decode to nothing.
  localparam cfg_idx_t REG_UNUSED_6 = 3'd6;
  localparam cfg_idx_t REG_UNUSED_7 = 3'd7;

  // One expected byte of a frame.
  typedef struct {
    byte_t value;
    logic  last;
    int    pos;
  } frame_beat_t;

  // One row of the directed table: a register write or a request.
  typedef struct packed {
    bit        is_cfg;
    cfg_idx_t  idx;
    cfg_data_t data;
    byte_t     seq;
    byte_t     sys;
    byte_t     comp;
    bit        typed;
    byte_t     start_exp;
  } row_t;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  byte_t     in_sequence_number = '0;
  byte_t     in_system_ident = '0;
  byte_t     in_component_ident = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  byte_t     out_frame_byte;
  logic      out_frame_end;
  logic      cfg_write = 1'b0;
  cfg_idx_t  cfg_index = '0;
  cfg_data_t cfg_data = '0;

  // Typed start byte travelling with the request currently offered.
  bit        cur_typed = 1'b0;
  byte_t     cur_start_exp = '0;

  // Shadow of the block's registers and latched request fields.
  byte_t       start_mark = RST_START_MARKER;
  logic [31:0] mode_word  = RST_CUSTOM_MODE;
  byte_t       vehicle    = RST_VEHICLE_TYPE;
  byte_t       autopilot  = RST_AUTOPILOT_TYPE;
  byte_t       state_val  = RST_STATE_BYTE;
  byte_t       crc_xtra   = RST_CRC_EXTRA;
  byte_t       latched_seq = '0;
  byte_t       latched_sys = '0;
  byte_t       latched_comp = '0;

  frame_beat_t frame_due [$];
  row_t        dir_rows [$];
  int unsigned mismatch_count = 0;
  int unsigned cycle_count = 0;
  bit          idle_en = 1'b1;
  bit          hold_request = 1'b0;

  heartbeat_frame_builder_core dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_sequence_number (in_sequence_number),
    .in_system_ident    (in_system_ident),
    .in_component_ident (in_component_ident),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_frame_byte     (out_frame_byte),
    .out_frame_end      (out_frame_end),
    .cfg_write          (cfg_write),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data)
  );

  // Clock and a single reset at the start.
  initial begin
    forever #4 clk = ~clk;
  end

  initial begin
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
  end

  // Run guard.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("%0t: run limit reached", $time);
      $display("Mismatches found");
      $finish;
    end
  end

  // Bitwise X.25 CRC step, reflected polynomial.
  function automatic crc_t x25_add(input crc_t crc, input byte_t b);
    crc_t r;
    int   k;
    r = crc ^ {8'h00, b};
    for (k = 0; k < 8; k++) begin
      r = r[0] ? ((r >> 1) ^ X25_POLY_REV) : (r >> 1);
    end
    return r;
  endfunction

  // Mirror a register write; unknown indexes are dropped, wide data is truncated.
  function automatic void apply_reg(input cfg_idx_t idx, input cfg_data_t data);
    case (idx)
      REG_START_MARKER:   start_mark = data[7:0];
      REG_CUSTOM_MODE:    mode_word  = data;
      REG_VEHICLE_TYPE:   vehicle    = data[7:0];
      REG_AUTOPILOT_TYPE: autopilot  = data[7:0];
      REG_STATE_BYTE:     state_val  = data[7:0];
      REG_CRC_EXTRA:      crc_xtra   = data[7:0];
      default: ;
    endcase
  endfunction

  // Build the whole frame for one request and queue its bytes.
  function automatic void predict_frame(input byte_t seq, input byte_t sys, input byte_t comp,
                                        input bit typed, input byte_t start_exp);
    byte_t       frame [FRAME_BYTES];
    crc_t        crc;
    int          p;
    frame_beat_t beat;
    latched_seq  = seq;
    latched_sys  = sys;
    latched_comp = comp;
    for (p = 0; p < FRAME_BYTES; p++) frame[p] = '0;
    frame[POS_START]   = start_mark;
    frame[POS_LEN]     = PAYLOAD_LEN;
    frame[POS_SEQ]     = latched_seq;
    frame[POS_SYS]     = latched_sys;
    frame[POS_COMP]    = latched_comp;
    frame[POS_MODE0]   = mode_word[7:0];
    frame[POS_MODE1]   = mode_word[15:8];
    frame[POS_MODE2]   = mode_word[23:16];
    frame[POS_MODE3]   = mode_word[31:24];
    frame[POS_VEHICLE] = vehicle;
    frame[POS_AUTOPIL] = autopilot;
    frame[POS_STATE]   = state_val;
    // The start byte is sent but left out of the checksum.
    crc = CRC_INIT;
    for (p = POS_LEN; p <= POS_STATE; p++) crc = x25_add(crc, frame[p]);
    crc = x25_add(crc, crc_xtra);
    frame[POS_CRC_LO] = crc[7:0];
    frame[POS_CRC_HI] = crc[15:8];
    // Typed rows of the table carry the start byte typed in by hand.
    if (typed) frame[POS_START] = start_exp;
    for (p = 0; p < FRAME_BYTES; p++) begin
      beat.value = frame[p];
      beat.last  = (p == POS_CRC_HI);
      beat.pos   = p;
      frame_due.push_back(beat);
    end
  endfunction

  task automatic note_mismatch(input string what, input int pos, input int exp_v,
                               input int act_v);
    $display("%0t: %s at byte %0d: expected %0h actual %0h", $time, what, pos, exp_v, act_v);
    mismatch_count++;
  endtask

  // Check each result transfer against the oldest expected byte, then predict new requests.
  always @(posedge clk) begin : frame_check
    frame_beat_t due_beat;
    if (rst_n && out_valid && !out_stall) begin
      if (frame_due.size() == 0) begin
        $display("%0t: unexpected byte: expected none actual %0h", $time, out_frame_byte);
        mismatch_count++;
      end else begin
        due_beat = frame_due.pop_front();
        if (out_frame_byte !== due_beat.value) begin
          note_mismatch("frame_byte", due_beat.pos, due_beat.value, out_frame_byte);
        end
        if (out_frame_end !== due_beat.last) begin
          note_mismatch("frame_end", due_beat.pos, due_beat.last, out_frame_end);
        end
      end
    end
    if (rst_n && in_valid && !in_stall) begin
      predict_frame(in_sequence_number, in_system_ident, in_component_ident,
                    cur_typed, cur_start_exp);
    end
  end

  // Receiver: random stalls, a long hold-off on request, or none at all.
  initial begin : receiver
    int unsigned hold_left;
    hold_left = 0;
    forever begin
      @(negedge clk);
      if (hold_left == 0 && hold_request) begin
        hold_left    = HOLD_CYCLES;
        hold_request = 1'b0;
      end
      if (hold_left != 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else if (idle_en) begin
        out_stall <= ($urandom_range(99) < IDLE_PCT);
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Offer one request, called at a falling edge; returns at the falling edge after its transfer.
  task automatic send_request(input byte_t seq, input byte_t sys, input byte_t comp,
                              input bit typed, input byte_t start_exp);
    while (idle_en && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid           <= 1'b1;
    in_sequence_number <= seq;
    in_system_ident    <= sys;
    in_component_ident <= comp;
    cur_typed          <= typed;
    cur_start_exp      <= start_exp;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  // Stop offering and wait until every expected byte has come out.
  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(negedge clk); while (frame_due.size() != 0);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // One register write pulse; only called while the block is idle.
  task automatic write_reg(input cfg_idx_t idx, input cfg_data_t data);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    apply_reg(idx, data);
    @(negedge clk);
    cfg_write <= 1'b0;
    @(negedge clk);
  endtask

  function automatic row_t cfg_row(input cfg_idx_t idx, input cfg_data_t data);
    row_t r;
    r        = '0;
    r.is_cfg = 1'b1;
    r.idx    = idx;
    r.data   = data;
    return r;
  endfunction

  function automatic row_t item_row(input byte_t seq, input byte_t sys, input byte_t comp,
                                    input bit typed, input byte_t start_exp);
    row_t r;
    r           = '0;
    r.seq       = seq;
    r.sys       = sys;
    r.comp      = comp;
    r.typed     = typed;
    r.start_exp = start_exp;
    return r;
  endfunction

  // Field value biased towards the extremes.
  function automatic byte_t pick_field();
    int unsigned r;
    r = $urandom_range(9);
    if (r == 0) return 8'h00;
    if (r == 1) return 8'hFF;
    return byte_t'($urandom_range(255));
  endfunction

  // Write each register: zeros, all ones or random; phases past 2 also write an unused index.
  task automatic program_phase(input int unsigned ph);
    int        i;
    cfg_data_t data;
    wait_drained();
    for (i = REG_START_MARKER; i <= REG_CRC_EXTRA; i++) begin
      if (ph == 1) data = '0;
      else if (ph == 2) data = '1;
      else data = $urandom();
      write_reg(cfg_idx_t'(i), data);
    end
    if (ph > 2) write_reg($urandom_range(1) ? REG_UNUSED_6 : REG_UNUSED_7, $urandom());
  endtask

  // Main sequence: directed table, random phases, then drain and verdict.
  initial begin : stimulus
    row_t        row;
    int unsigned ph;
    int unsigned n;

    // Reset defaults, then all zeros, all ones, truncated and ignored writes.
    dir_rows.push_back(item_row(8'h00, 8'h00, 8'h00, 1'b1, RST_START_MARKER));
    dir_rows.push_back(item_row(8'hFF, 8'hFF, 8'hFF, 1'b1, RST_START_MARKER));
    dir_rows.push_back(item_row(8'h01, 8'h80, 8'h55, 1'b0, 8'h00));
    dir_rows.push_back(cfg_row(REG_START_MARKER, 32'h0000_0000));
    dir_rows.push_back(cfg_row(REG_CUSTOM_MODE, 32'h0000_0000));
    dir_rows.push_back(cfg_row(REG_VEHICLE_TYPE, 32'h0000_0000));
    dir_rows.push_back(cfg_row(REG_AUTOPILOT_TYPE, 32'h0000_0000));
    dir_rows.push_back(cfg_row(REG_STATE_BYTE, 32'h0000_0000));
    dir_rows.push_back(cfg_row(REG_CRC_EXTRA, 32'h0000_0000));
    dir_rows.push_back(item_row(8'h00, 8'h00, 8'h00, 1'b1, 8'h00));
    dir_rows.push_back(cfg_row(REG_START_MARKER, 32'h0000_00FF));
    dir_rows.push_back(cfg_row(REG_CUSTOM_MODE, 32'hFFFF_FFFF));
    dir_rows.push_back(cfg_row(REG_VEHICLE_TYPE, 32'h0000_00FF));
    dir_rows.push_back(cfg_row(REG_AUTOPILOT_TYPE, 32'h0000_00FF));
    dir_rows.push_back(cfg_row(REG_STATE_BYTE, 32'h0000_00FF));
    dir_rows.push_back(cfg_row(REG_CRC_EXTRA, 32'h0000_00FF));
    dir_rows.push_back(item_row(8'hFF, 8'hFF, 8'hFF, 1'b1, 8'hFF));
    dir_rows.push_back(cfg_row(REG_START_MARKER, 32'hABCD_12FE));
    dir_rows.push_back(cfg_row(REG_UNUSED_6, 32'h0000_0011));
    dir_rows.push_back(cfg_row(REG_UNUSED_7, 32'h0000_0022));
    dir_rows.push_back(item_row(8'h12, 8'h34, 8'h56, 1'b1, 8'hFE));
    dir_rows.push_back(cfg_row(REG_CUSTOM_MODE, 32'h1234_5678));
    dir_rows.push_back(cfg_row(REG_CRC_EXTRA, 32'h7700_0032));
    dir_rows.push_back(item_row(8'hAA, 8'h55, 8'h0F, 1'b0, 8'h00));
    dir_rows.push_back(item_row(8'h0F, 8'hF0, 8'hA5, 1'b0, 8'h00));

    @(posedge rst_n);
    @(negedge clk);

    foreach (dir_rows[k]) begin
      row = dir_rows[k];
      if (row.is_cfg) begin
        wait_drained();
        write_reg(row.idx, row.data);
      end else begin
        send_request(row.seq, row.sys, row.comp, row.typed, row.start_exp);
      end
    end

    // Random phases; one holds the receiver off, one runs with no idling.
    for (ph = 0; ph < PHASES; ph++) begin
      program_phase(ph);
      idle_en = (ph != 4);
      if (ph == 3) hold_request = 1'b1;
      for (n = 0; n < PHASE_ITEMS; n++) begin
        send_request(pick_field(), pick_field(), pick_field(), 1'b0, 8'h00);
      end
    end

    wait_drained();
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

/* filelist.f */
sv/hfb_pkg.sv
sv/heartbeat_frame_builder_core.sv
sv/hfb_checker.sv
verif/tb_top.sv
